// ===== rtl/core/bitmap_region_allocator_macros.svh =====
// assertion macros for the bitmap region allocator
`ifndef BITMAP_REGION_ALLOCATOR_MACROS_SVH
`define BITMAP_REGION_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk, off while rst_n is low
`define BRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRA_ASSERT_IMP(lbl, ante, cons, msg)
`define BRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/bra_pkg.sv =====
// types and constants of the bitmap region allocator
package bra_pkg;

  localparam int DEF_BITS      = 256;
  localparam int DEF_WORD_BITS = 8;

  localparam int KIND_W     = 2;
  localparam int POS_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 2'd0,
    KIND_CLR   = 2'd1,
    KIND_QRY   = 2'd2,
    KIND_ALLOC = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_NOFIT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RESTART,
    ST_WALK,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/bitmap_region_allocator.sv =====
// bitmap region allocator: range set, clear, query and first-fit allocate
//
// requests enter on in_* (tuser = kind, tdata = position, bit_count), one
// result per request leaves on out_* (status, query flags, region start,
// empty, full and free count). cfg_* writes the map size; it is taken at
// any time, clears the map and reloads the free count.
// after reset and after a size write a clearing pass writes zero to every
// map word, one word per cycle, and in_tready stays low.
// the map lives in a single-port-write memory read one word per cycle; a
// shared word unit masks, counts and scans that word. one request at a time:
//   zero length, bounds or free-count rejects: go straight to the finish step
//   set, clear, query: walk the words up to the last word of the range
//   allocate: walk the words until a run fits or the map ends, and when
//             found walk again from word 0 up to the end of the run to mark it
// the result sits in an output register; while it waits on out_tready one
// more request is still taken and worked through, then held in its finish
// step until the register is free
`include "bitmap_region_allocator_macros.svh"

module bitmap_region_allocator import bra_pkg::*; #(
  parameter int BITS      = DEF_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] position, [16:8] bit_count, [23:17] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [2] any_set, [3] none_set, [4] all_set, [12:5] region_start,
  // [13] map_empty, [14] map_full, [23:15] free_bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data
);

  localparam int NWORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = $clog2(WORD_BITS + 1);
  localparam int SZ_CAP = (BITS > 511) ? 511 : BITS;
  localparam logic [AW-1:0] LAST_W = AW'(NWORDS - 1);

  function automatic logic [SIZE_W-1:0] eff_of(input logic [SIZE_W-1:0] v);
    eff_of = (v > SIZE_W'(SZ_CAP)) ? SIZE_W'(SZ_CAP) : v;
  endfunction

  // map storage
  logic [WORD_BITS-1:0] map_mem_r [NWORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  kind_t                 walk_op_r, walk_op_nxt;
  status_t               status_r, status_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [SIZE_W-1:0]     free_r, free_nxt;
  logic [SIZE_W-1:0]     cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]     run_r, run_nxt;
  logic [AW-1:0]         w_r, w_nxt;
  logic [IDX_W-1:0]      base_r, base_nxt;
  logic [IDX_W-1:0]      lo_r, lo_nxt;
  logic [IDX_W-1:0]      hi_r, hi_nxt;
  logic [IDX_W-1:0]      start_r, start_nxt;
  logic                  any_r, any_nxt;
  logic                  all_r, all_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [SIZE_W-1:0] size_eff;
  kind_t             req_kind;
  logic [POS_W-1:0]  req_pos;
  logic [SIZE_W-1:0] req_cnt;
  logic [IDX_W-1:0]  req_end;
  logic              req_walk;
  status_t           req_status;

  logic [WORD_BITS-1:0] in_rng;
  logic [CW-1:0]        pop_set;
  logic [CW-1:0]        pop_clr;
  logic                 hit_any;
  logic                 hit_all;
  logic [SIZE_W-1:0]    run_w;
  logic                 fnd_w;
  logic [IDX_W-1:0]     fst_w;
  logic                 last_word;
  logic                 slot_free;

  assign size_eff  = eff_of(size_r);
  assign req_kind  = kind_t'(in_tuser);
  assign req_pos   = in_tdata[POS_W-1:0];
  assign req_cnt   = in_tdata[POS_W+SIZE_W-1:POS_W];
  assign req_end   = IDX_W'(req_pos) + IDX_W'(req_cnt);
  assign slot_free = !out_tvalid_r || out_tready;
  assign last_word = ((base_r + IDX_W'(WORD_BITS)) >= hi_r) || (w_r == LAST_W);

  // request decode: early rejects never walk the map
  always_comb begin
    req_walk   = 1'b0;
    req_status = STS_OK;
    if (req_cnt == '0) begin
      req_status = STS_RANGE;
    end else if (req_kind == KIND_ALLOC) begin
      req_status = STS_NOFIT;
      req_walk   = (req_cnt <= size_eff);
    end else if (req_end > IDX_W'(size_eff)) begin
      req_status = STS_RANGE;
    end else if (req_kind == KIND_SET && free_r < req_cnt) begin
      req_status = STS_NOFIT;
    end else begin
      req_walk = 1'b1;
    end
  end

  // shared word unit: range mask, changed-bit counts, query flags, run scan
  always_comb begin
    logic [IDX_W-1:0]     bidx;
    logic [WORD_BITS-1:0] set_chg;
    logic [WORD_BITS-1:0] clr_chg;
    logic [SIZE_W-1:0]    run;
    logic                 fnd;
    logic [IDX_W-1:0]     fst;
    for (int j = 0; j < WORD_BITS; j++) begin
      bidx      = base_r + IDX_W'(j);
      in_rng[j] = (bidx >= lo_r) && (bidx < hi_r);
    end
    set_chg = in_rng & ~rd_data_r;
    clr_chg = in_rng & rd_data_r;
    pop_set = '0;
    pop_clr = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pop_set = pop_set + CW'(set_chg[j]);
      pop_clr = pop_clr + CW'(clr_chg[j]);
    end
    hit_any = |(rd_data_r & in_rng);
    hit_all = &(rd_data_r | ~in_rng);
    // run length carries across words; stop at the first run that fits
    run = run_r;
    fnd = 1'b0;
    fst = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!fnd && in_rng[j]) begin
        if (rd_data_r[j]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == cnt_r) begin
            fnd = 1'b1;
            fst = base_r + IDX_W'(j) + 1'b1 - IDX_W'(cnt_r);
          end
        end
      end
    end
    run_w = run;
    fnd_w = fnd;
    fst_w = fst;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = req_walk ? ST_WALK : ST_FIN;
        end
      end
      ST_CLEAR: begin
        if (w_r == LAST_W) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESTART: state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_op_r == KIND_ALLOC && fnd_w) begin
          state_nxt = ST_RESTART;
        end else if (last_word) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_valid) begin
      state_nxt = ST_CLEAR;
    end
  end

  // handshake and memory controls
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_CLEAR: mem_we = 1'b1;
      ST_WALK: begin
        mem_raddr = (w_r == LAST_W) ? '0 : w_r + 1'b1;
        case (walk_op_r)
          KIND_SET: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r | in_rng;
          end
          KIND_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r & ~in_rng;
          end
          default: mem_we = 1'b0;
        endcase
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  // datapath
  always_comb begin
    logic qry_ok;
    logic alloc_ok;
    kind_nxt       = kind_r;
    walk_op_nxt    = walk_op_r;
    status_nxt     = status_r;
    size_nxt       = size_r;
    free_nxt       = free_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    w_nxt          = w_r;
    base_nxt       = base_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    start_nxt      = start_r;
    any_nxt        = any_r;
    all_nxt        = all_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    qry_ok         = (kind_r == KIND_QRY) && (status_r == STS_OK);
    alloc_ok       = (kind_r == KIND_ALLOC) && (status_r == STS_OK);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = req_kind;
          walk_op_nxt = req_kind;
          status_nxt  = req_status;
          cnt_nxt     = req_cnt;
          run_nxt     = '0;
          w_nxt       = '0;
          base_nxt    = '0;
          start_nxt   = '0;
          any_nxt     = 1'b0;
          all_nxt     = 1'b1;
          if (req_kind == KIND_ALLOC) begin
            lo_nxt = '0;
            hi_nxt = IDX_W'(size_eff);
          end else begin
            lo_nxt = IDX_W'(req_pos);
            hi_nxt = req_end;
          end
        end
      end
      ST_CLEAR: begin
        if (w_r != LAST_W) begin
          w_nxt = w_r + 1'b1;
        end
      end
      ST_WALK: begin
        case (walk_op_r)
          KIND_SET: free_nxt = free_r - SIZE_W'(pop_set);
          KIND_CLR: free_nxt = free_r + SIZE_W'(pop_clr);
          KIND_QRY: begin
            any_nxt = any_r | hit_any;
            all_nxt = all_r & hit_all;
          end
          default: run_nxt = run_w;
        endcase
        if (walk_op_r == KIND_ALLOC && fnd_w) begin
          // found: walk again from word 0 and mark the run
          start_nxt   = fst_w;
          lo_nxt      = fst_w;
          hi_nxt      = fst_w + IDX_W'(cnt_r);
          walk_op_nxt = KIND_SET;
          status_nxt  = STS_OK;
          w_nxt       = '0;
          base_nxt    = '0;
        end else if (!last_word) begin
          w_nxt    = w_r + 1'b1;
          base_nxt = base_r + IDX_W'(WORD_BITS);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {free_r,
                            free_r == '0,
                            free_r == size_eff,
                            alloc_ok ? start_r[POS_W-1:0] : POS_W'(0),
                            qry_ok && all_r,
                            qry_ok && !any_r,
                            qry_ok && any_r,
                            status_r};
        end
      end
      default: w_nxt = w_r;
    endcase
    if (cfg_valid) begin
      size_nxt = cfg_data;
      free_nxt = eff_of(cfg_data);
      w_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      size_r       <= SIZE_RESET;
      free_r       <= eff_of(SIZE_RESET);
      w_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      size_r       <= size_nxt;
      free_r       <= free_nxt;
      w_r          <= w_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    walk_op_r   <= walk_op_nxt;
    status_r    <= status_nxt;
    cnt_r       <= cnt_nxt;
    run_r       <= run_nxt;
    base_r      <= base_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    start_r     <= start_nxt;
    any_r       <= any_nxt;
    all_r       <= all_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem_r[w_r] <= mem_wdata;
    end
    rd_data_r <= map_mem_r[mem_raddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `BRA_ASSERT_IMP(a_free_in_size, 1'b1, free_r <= size_eff, "free count above map size")
  `BRA_ASSERT_IMP(a_out_from_fin, $rose(out_tvalid_r), $past(state_r) == ST_FIN,
                  "result loaded outside finish state")
  `BRA_ASSERT_IMP(a_walk_in_range, state_r == ST_WALK, base_r < hi_r,
                  "word walk past end of range")
  `BRA_ASSERT_NXT(a_cfg_clears, cfg_valid, state_r == ST_CLEAR,
                  "size write did not start clearing pass")

endmodule
